// ===== hdl/prrs_pkg.sv =====
// Shared types, constants and status codes for the priority round-robin scheduler.
package prrs_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int PRIO_W    = 4;
    localparam int TIME_W    = 16;
    localparam int ID_W      = 5;
    localparam int TURN_W    = 21;
    localparam int WAIT_W    = 26;
    localparam int LOADED_W  = 6;
    localparam int ENTRY_W   = PRIO_W + TIME_W;

    localparam int PROD_W    = TIME_W + CNT_W;
    localparam int WSUM_W    = ((PROD_W > WAIT_W) ? PROD_W : WAIT_W) + 1;

    localparam logic [TIME_W-1:0] TQ_RESET = 16'd10;

    // result status codes
    localparam logic [1:0] ST_LOADED   = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_SLICE    = 2'd2;
    localparam logic [1:0] ST_ALL_DONE = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] rem;
    } entry_t;

endpackage

// ===== hdl/prrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/priority_round_robin_scheduler.sv =====
// Top level of the priority scheduler with round robin inside a priority level.
//
// Each item is a command taken when start is high and busy is low. A load
// (mode 0) stores a task in a free table entry and answers in the next cycle. A
// slice request (mode 1) walks the task table through its single read port,
// one entry per cycle, pipelined behind the registered read. If a shared
// group is running, the walk first looks for the next group member after the
// one that ran last, wrapping, and stops at the first hit; if there is none,
// or no group is active, a full walk finds the highest unfinished level
// (earliest entry wins ties) and counts its members in the same pass. The
// states S_CALC, S_MUL and S_UPD then size the slice, form the waiting
// increment on the one multiplier, and write back the entry and totals. With
// nothing left to run, status 3 comes as soon as the full walk ends. The
// result appears on the output ports for exactly one cycle with done high;
// there is no backpressure, so the receiver must take it then. busy is high
// while a slice request is worked on and drops as the result strobe rises;
// a load never raises busy. time_quantum is written over the cfg channel,
// which is always ready and should be used only while the block is idle; 0
// acts as 1. Running totals saturate. The table is not cleared after reset:
// only entries below the loaded count are ever read.
module priority_round_robin_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [prrs_pkg::PRIO_W-1:0]   priority_req,
    input  logic [prrs_pkg::TIME_W-1:0]   burst,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prrs_pkg::TIME_W-1:0]   cfg_data,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [prrs_pkg::ID_W-1:0]     task_id,
    output logic [prrs_pkg::TIME_W-1:0]   slice_length,
    output logic [prrs_pkg::TURN_W-1:0]   turnaround_sum,
    output logic [prrs_pkg::WAIT_W-1:0]   waiting_sum,
    output logic [prrs_pkg::LOADED_W-1:0] tasks_loaded
);

    localparam int IDX_W  = prrs_pkg::IDX_W;
    localparam int CNT_W  = prrs_pkg::CNT_W;
    localparam int PRIO_W = prrs_pkg::PRIO_W;
    localparam int TIME_W = prrs_pkg::TIME_W;
    localparam int PROD_W = prrs_pkg::PROD_W;
    localparam int WSUM_W = prrs_pkg::WSUM_W;
    localparam int TURN_W = prrs_pkg::TURN_W;
    localparam int WAIT_W = prrs_pkg::WAIT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command
    localparam logic [2:0] S_GRP  = 3'd1;  // look for next member of the running group
    localparam logic [2:0] S_TOP  = 3'd2;  // full walk for top level and its count
    localparam logic [2:0] S_CALC = 3'd3;  // size the slice
    localparam logic [2:0] S_MUL  = 3'd4;  // waiting increment
    localparam logic [2:0] S_UPD  = 3'd5;  // write back, emit

    logic [2:0]             state_reg,       state_next;
    logic [TIME_W-1:0]      tq_reg,          tq_next;
    logic [CNT_W-1:0]       task_total_reg,  task_total_next;
    logic [CNT_W-1:0]       unfinished_reg,  unfinished_next;
    logic                   level_active_reg, level_active_next;
    logic [PRIO_W-1:0]      cur_level_reg,   cur_level_next;
    logic [IDX_W-1:0]       rr_reg,          rr_next;
    logic [TURN_W-1:0]      turn_reg,        turn_next;
    logic [WAIT_W-1:0]      wait_reg,        wait_next;

    // table walk
    logic [IDX_W-1:0]       scan_addr_reg,   scan_addr_next;
    logic [CNT_W-1:0]       left_reg,        left_next;
    logic                   pipe_vld_reg,    pipe_vld_next;
    logic [IDX_W-1:0]       pipe_idx_reg,    pipe_idx_next;
    logic                   hit_reg,         hit_next;
    logic [IDX_W-1:0]       chosen_reg,      chosen_next;
    logic [PRIO_W-1:0]      chosen_prio_reg, chosen_prio_next;
    logic [TIME_W-1:0]      chosen_rem_reg,  chosen_rem_next;
    logic [CNT_W-1:0]       count_reg,       count_next;
    logic                   lone_reg,        lone_next;
    logic [TIME_W-1:0]      slice_reg,       slice_next;
    logic [PROD_W-1:0]      prod_reg,        prod_next;

    // result registers
    logic                   done_reg,        done_next;
    logic [1:0]             status_reg,      status_next;
    logic [prrs_pkg::ID_W-1:0] id_reg,       id_next;
    logic [TIME_W-1:0]      slice_out_reg,   slice_out_next;

    // table port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    prrs_pkg::entry_t       ram_wentry;
    logic [prrs_pkg::ENTRY_W-1:0] ram_rdata;
    prrs_pkg::entry_t       rd_entry;

    logic                   issue;
    logic [TIME_W-1:0]      quantum;
    logic [TURN_W:0]        turn_sum;
    logic [WSUM_W-1:0]      wait_sum;
    logic [TIME_W-1:0]      new_rem;

    // next table index, wrapping at the loaded count
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] total);
        logic [CNT_W-1:0] nxt;
        begin
            nxt = CNT_W'(a) + CNT_W'(1);
            wrap_inc = (nxt >= total) ? '0 : IDX_W'(nxt);
        end
    endfunction

    prrs_ram #(
        .WIDTH (prrs_pkg::ENTRY_W),
        .DEPTH (prrs_pkg::MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry  = prrs_pkg::entry_t'(ram_rdata);
    assign quantum   = (tq_reg == '0) ? TIME_W'(1) : tq_reg;
    assign new_rem   = chosen_rem_reg - slice_reg;
    assign turn_sum  = (TURN_W+1)'(turn_reg) + (TURN_W+1)'(slice_reg);
    assign wait_sum  = WSUM_W'(wait_reg) + WSUM_W'(prod_reg);

    // one table read per cycle while walking; group walk stops on a hit
    assign issue = ((state_reg == S_GRP && !hit_reg) || state_reg == S_TOP)
                   && (left_reg != '0);

    always_comb
    begin
        state_next        = state_reg;
        tq_next           = tq_reg;
        task_total_next   = task_total_reg;
        unfinished_next   = unfinished_reg;
        level_active_next = level_active_reg;
        cur_level_next    = cur_level_reg;
        rr_next           = rr_reg;
        turn_next         = turn_reg;
        wait_next         = wait_reg;
        scan_addr_next    = scan_addr_reg;
        left_next         = left_reg;
        hit_next          = hit_reg;
        chosen_next       = chosen_reg;
        chosen_prio_next  = chosen_prio_reg;
        chosen_rem_next   = chosen_rem_reg;
        count_next        = count_reg;
        lone_next         = lone_reg;
        slice_next        = slice_reg;
        prod_next         = prod_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        id_next           = id_reg;
        slice_out_next    = slice_out_reg;
        ram_we            = 1'b0;
        ram_waddr         = chosen_reg;
        ram_wentry.prio   = chosen_prio_reg;
        ram_wentry.rem    = new_rem;

        pipe_vld_next = issue;
        pipe_idx_next = scan_addr_reg;
        if (issue)
        begin
            scan_addr_next = wrap_inc(scan_addr_reg, task_total_reg);
            left_next      = left_reg - CNT_W'(1);
        end

        if (cfg_valid && cfg_ready)
        begin
            tq_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        done_next      = 1'b1;
                        slice_out_next = '0;
                        if (task_total_reg >= CNT_W'(prrs_pkg::MAX_TASKS))
                        begin
                            status_next = prrs_pkg::ST_FULL;
                            id_next     = '0;
                        end
                        else
                        begin
                            status_next     = prrs_pkg::ST_LOADED;
                            id_next         = prrs_pkg::ID_W'(task_total_reg);
                            ram_we          = 1'b1;
                            ram_waddr       = IDX_W'(task_total_reg);
                            ram_wentry.prio = priority_req;
                            ram_wentry.rem  = burst;
                            task_total_next = task_total_reg + CNT_W'(1);
                            if (burst != '0)
                            begin
                                unfinished_next = unfinished_reg + CNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        count_next = '0;
                        left_next  = task_total_reg;
                        if (level_active_reg && task_total_reg != '0)
                        begin
                            state_next     = S_GRP;
                            scan_addr_next = wrap_inc(rr_reg, task_total_reg);
                        end
                        else
                        begin
                            state_next     = S_TOP;
                            scan_addr_next = '0;
                        end
                    end
                end
            end

            S_GRP:
            begin
                if (pipe_vld_reg && !hit_reg && rd_entry.rem != '0
                    && rd_entry.prio == cur_level_reg)
                begin
                    hit_next         = 1'b1;
                    chosen_next      = pipe_idx_reg;
                    chosen_prio_next = rd_entry.prio;
                    chosen_rem_next  = rd_entry.rem;
                end
                if (hit_reg)
                begin
                    lone_next  = 1'b0;
                    state_next = S_CALC;
                end
                else if (left_reg == '0 && !pipe_vld_reg)
                begin
                    // group exhausted: fall back to a full walk
                    level_active_next = 1'b0;
                    state_next        = S_TOP;
                    scan_addr_next    = '0;
                    left_next         = task_total_reg;
                    hit_next          = 1'b0;
                    count_next        = '0;
                end
            end

            S_TOP:
            begin
                if (pipe_vld_reg && rd_entry.rem != '0)
                begin
                    if (!hit_reg || rd_entry.prio > chosen_prio_reg)
                    begin
                        hit_next         = 1'b1;
                        chosen_next      = pipe_idx_reg;
                        chosen_prio_next = rd_entry.prio;
                        chosen_rem_next  = rd_entry.rem;
                        count_next       = CNT_W'(1);
                    end
                    else if (rd_entry.prio == chosen_prio_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                if (left_reg == '0 && !pipe_vld_reg)
                begin
                    level_active_next = hit_reg && (count_reg != CNT_W'(1));
                    if (!hit_reg)
                    begin
                        done_next      = 1'b1;
                        status_next    = prrs_pkg::ST_ALL_DONE;
                        id_next        = '0;
                        slice_out_next = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        lone_next = (count_reg == CNT_W'(1));
                        if (count_reg != CNT_W'(1))
                        begin
                            cur_level_next = chosen_prio_reg;
                        end
                        state_next = S_CALC;
                    end
                end
            end

            S_CALC:
            begin
                if (!lone_reg && chosen_rem_reg > quantum)
                begin
                    slice_next = quantum;
                end
                else
                begin
                    slice_next = chosen_rem_reg;
                end
                if (level_active_reg)
                begin
                    rr_next = chosen_reg;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(slice_reg) * PROD_W'(unfinished_reg - CNT_W'(1));
                state_next = S_UPD;
            end

            S_UPD:
            begin
                ram_we    = 1'b1;
                turn_next = turn_sum[TURN_W] ? '1 : turn_sum[TURN_W-1:0];
                wait_next = (wait_sum > WSUM_W'({WAIT_W{1'b1}})) ? '1
                                                                 : WAIT_W'(wait_sum);
                if (new_rem == '0)
                begin
                    unfinished_next = unfinished_reg - CNT_W'(1);
                end
                done_next      = 1'b1;
                status_next    = prrs_pkg::ST_SLICE;
                id_next        = prrs_pkg::ID_W'(chosen_reg);
                slice_out_next = slice_reg;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tq_reg           <= prrs_pkg::TQ_RESET;
            task_total_reg   <= '0;
            unfinished_reg   <= '0;
            level_active_reg <= 1'b0;
            cur_level_reg    <= '0;
            rr_reg           <= '0;
            turn_reg         <= '0;
            wait_reg         <= '0;
            scan_addr_reg    <= '0;
            left_reg         <= '0;
            pipe_vld_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tq_reg           <= tq_next;
            task_total_reg   <= task_total_next;
            unfinished_reg   <= unfinished_next;
            level_active_reg <= level_active_next;
            cur_level_reg    <= cur_level_next;
            rr_reg           <= rr_next;
            turn_reg         <= turn_next;
            wait_reg         <= wait_next;
            scan_addr_reg    <= scan_addr_next;
            left_reg         <= left_next;
            pipe_vld_reg     <= pipe_vld_next;
            hit_reg          <= hit_next;
            done_reg         <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pipe_idx_reg    <= pipe_idx_next;
        chosen_reg      <= chosen_next;
        chosen_prio_reg <= chosen_prio_next;
        chosen_rem_reg  <= chosen_rem_next;
        count_reg       <= count_next;
        lone_reg        <= lone_next;
        slice_reg       <= slice_next;
        prod_reg        <= prod_next;
        status_reg      <= status_next;
        id_reg          <= id_next;
        slice_out_reg   <= slice_out_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign status         = status_reg;
    assign task_id        = id_reg;
    assign slice_length   = slice_out_reg;
    assign turnaround_sum = turn_reg;
    assign waiting_sum    = wait_reg;
    assign tasks_loaded   = (32'(task_total_reg) > 32'd63) ? 6'd63
                                                           : prrs_pkg::LOADED_W'(task_total_reg);

endmodule

// ===== hdl/prrs_checker.sv =====
// Port-level checks for the priority round-robin scheduler, bound to the top level.
module prrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          mode,
    input logic [prrs_pkg::PRIO_W-1:0]   priority_req,
    input logic [prrs_pkg::TIME_W-1:0]   burst,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [prrs_pkg::TIME_W-1:0]   cfg_data,
    input logic                          done,
    input logic [1:0]                    status,
    input logic [prrs_pkg::ID_W-1:0]     task_id,
    input logic [prrs_pkg::TIME_W-1:0]   slice_length,
    input logic [prrs_pkg::TURN_W-1:0]   turnaround_sum,
    input logic [prrs_pkg::WAIT_W-1:0]   waiting_sum,
    input logic [prrs_pkg::LOADED_W-1:0] tasks_loaded
);

    // a load answers in the next cycle with a load status
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> done
            && (status == prrs_pkg::ST_LOADED || status == prrs_pkg::ST_FULL))
        else $error("load not answered next cycle");

    // a slice result carries work, any other result carries none
    a_slice_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == prrs_pkg::ST_SLICE) == (slice_length != '0)))
        else $error("slice length does not match status");

    // totals never decrease
    a_totals_mono: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> turnaround_sum >= $past(turnaround_sum)
            && waiting_sum >= $past(waiting_sum))
        else $error("running total decreased");

    // a rejected load means the table is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == prrs_pkg::ST_FULL
            |-> 32'(tasks_loaded) == ((prrs_pkg::MAX_TASKS > 63) ? 63 : prrs_pkg::MAX_TASKS))
        else $error("load rejected with free table entries");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (.*);

// ===== sim/tb_priority_round_robin_scheduler.sv =====
// Self-checking testbench for the priority round-robin scheduler: directed and random command streams.
module tb_priority_round_robin_scheduler;

    import prrs_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int SCAN_CYCLES = 2 * MAX_TASKS + 10;   // worst slice request plus margin
    localparam int QUIET_LIMIT = 20 * SCAN_CYCLES;     // watchdog: cycles with nothing taken
    localparam longint TURN_SAT = (64'd1 << TURN_W) - 1;
    localparam longint WAIT_SAT = (64'd1 << WAIT_W) - 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] burst;
    } sched_cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   len;
        logic [TURN_W-1:0]   turn_sum;
        logic [WAIT_W-1:0]   wait_sum;
        logic [LOADED_W-1:0] loaded;
    } sched_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                mode = 1'b0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic [TIME_W-1:0]   burst = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TIME_W-1:0]   cfg_data = '0;
    logic                done;
    logic [1:0]          status;
    logic [ID_W-1:0]     task_id;
    logic [TIME_W-1:0]   slice_length;
    logic [TURN_W-1:0]   turnaround_sum;
    logic [WAIT_W-1:0]   waiting_sum;
    logic [LOADED_W-1:0] tasks_loaded;

    priority_round_robin_scheduler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .priority_req   (priority_req),
        .burst          (burst),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .task_id        (task_id),
        .slice_length   (slice_length),
        .turnaround_sum (turnaround_sum),
        .waiting_sum    (waiting_sum),
        .tasks_loaded   (tasks_loaded)
    );

    initial forever #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Scheduler shadow: task table, group state, running totals
    // ---------------------------------------------------------------
    logic [PRIO_W-1:0] prio_tab [MAX_TASKS];
    logic [TIME_W-1:0] left_tab [MAX_TASKS];
    int                n_tasks = 0;        // tasks loaded
    int                n_open = 0;         // tasks with time left
    bit                grp_on = 1'b0;      // shared level being worked through
    logic [PRIO_W-1:0] grp_level = '0;
    int                rr_last = 0;        // group member that ran last
    longint            turn_acc = 0;
    longint            wait_acc = 0;
    logic [TIME_W-1:0] slice_quantum = TQ_RESET;

    sched_cmd_t    cmd_q[$];         // items waiting to be driven
    sched_result_t due_results[$];   // predicted results, oldest first

    int items_planned = 0;
    int items_sent = 0;
    int items_taken = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    int n_errors = 0;
    int loads_left = MAX_TASKS;
    bit gaps_on = 1'b1;

    function automatic sched_result_t schedule_step(input logic m, input logic [PRIO_W-1:0] p,
                                                    input logic [TIME_W-1:0] b);
        sched_result_t r;
        int pick;
        int j;
        int members;
        bit hit;
        bit lone;
        logic [TIME_W-1:0] q_eff;
        logic [TIME_W-1:0] run;
        longint step_len;
        r = '0;
        pick = 0;
        members = 0;
        hit = 1'b0;
        lone = 1'b0;
        if (m == MODE_LOAD)
        begin
            if (n_tasks >= MAX_TASKS)
                r.status = ST_FULL;
            else
            begin
                prio_tab[n_tasks] = p;
                left_tab[n_tasks] = b;
                r.status = ST_LOADED;
                r.id = n_tasks[ID_W-1:0];
                n_tasks++;
                if (b != 0)
                    n_open++;
            end
        end
        else
        begin
            // a running group continues with the next member after the last one, wrapping
            if (grp_on && n_tasks > 0)
            begin
                for (int k = 1; k <= n_tasks && !hit; k++)
                begin
                    j = (rr_last + k) % n_tasks;
                    if (left_tab[j] != 0 && prio_tab[j] == grp_level)
                    begin
                        pick = j;
                        hit = 1'b1;
                    end
                end
            end
            // otherwise: highest unfinished level, earliest entry on ties
            if (!hit)
            begin
                grp_on = 1'b0;
                for (int i = 0; i < n_tasks; i++)
                begin
                    if (left_tab[i] != 0 && (!hit || prio_tab[i] > prio_tab[pick]))
                    begin
                        pick = i;
                        hit = 1'b1;
                    end
                end
                if (hit)
                begin
                    for (int i = 0; i < n_tasks; i++)
                        if (left_tab[i] != 0 && prio_tab[i] == prio_tab[pick])
                            members++;
                    if (members == 1)
                        lone = 1'b1;
                    else
                    begin
                        grp_on = 1'b1;
                        grp_level = prio_tab[pick];
                    end
                end
            end
            if (!hit)
                r.status = ST_ALL_DONE;
            else
            begin
                q_eff = (slice_quantum == 0) ? TIME_W'(1) : slice_quantum;
                run = left_tab[pick];
                if (!lone && run > q_eff)
                    run = q_eff;
                if (grp_on)
                    rr_last = pick;
                step_len = run;
                turn_acc += step_len;
                if (turn_acc > TURN_SAT)
                    turn_acc = TURN_SAT;
                wait_acc += step_len * (n_open - 1);
                if (wait_acc > WAIT_SAT)
                    wait_acc = WAIT_SAT;
                left_tab[pick] = left_tab[pick] - run;
                if (left_tab[pick] == 0)
                    n_open--;
                r.status = ST_SLICE;
                r.id = pick[ID_W-1:0];
                r.len = run;
            end
        end
        r.turn_sum = turn_acc[TURN_W-1:0];
        r.wait_sum = wait_acc[WAIT_W-1:0];
        r.loaded = LOADED_W'((n_tasks > 63) ? 63 : n_tasks);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (after %0d items taken)",
                 what, got, want, items_taken);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // Driver: presents queued items at the falling edge, with random gaps
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        sched_cmd_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || items_taken == items_sent)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_q.size() != 0 && gaps_on && $urandom_range(0, 4) == 0)
            begin
                gap_left = $urandom_range(0, 4);   // random idle gap before the next item
                start <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                nxt = cmd_q.pop_front();
                start <= 1'b1;
                mode <= nxt.mode;
                priority_req <= nxt.prio;
                burst <= nxt.burst;
                items_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results, predicts on accept, tracks quantum writes
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n)
        begin
            // result check first: an item taken at this edge answers later
            if (done)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with no item pending", status, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (task_id !== want.id)
                        report_mismatch("task_id", task_id, want.id);
                    if (slice_length !== want.len)
                        report_mismatch("slice_length", slice_length, want.len);
                    if (turnaround_sum !== want.turn_sum)
                        report_mismatch("turnaround_sum", turnaround_sum, want.turn_sum);
                    if (waiting_sum !== want.wait_sum)
                        report_mismatch("waiting_sum", waiting_sum, want.wait_sum);
                    if (tasks_loaded !== want.loaded)
                        report_mismatch("tasks_loaded", tasks_loaded, want.loaded);
                end
            end
            if (start && !busy)
            begin
                due_results.push_back(schedule_step(mode, priority_req, burst));
                items_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                slice_quantum = cfg_data;
                cfg_writes++;
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_load(input logic [PRIO_W-1:0] p, input logic [TIME_W-1:0] b);
        cmd_q.push_back('{MODE_LOAD, p, b});
        items_planned++;
    endtask

    // slice request; the unused fields carry random bits
    task automatic push_step();
        cmd_q.push_back('{MODE_STEP, PRIO_W'($urandom), TIME_W'($urandom)});
        items_planned++;
    endtask

    // mostly short bursts; long ones only when the quantum keeps slice counts low
    function automatic logic [TIME_W-1:0] pick_burst(input int qi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6 && qi >= 4096)
            return '1;
        if (r < 15 && qi >= 256)
            return TIME_W'($urandom_range(256, 65535));
        return TIME_W'($urandom_range(1, 60));
    endfunction

    // one well-formed round: a few loads mostly at one level, then enough
    // slice requests to work them off, with the odd load mid-group
    task automatic plan_round();
        int qi;
        int n_new;
        int cost;
        int ncost;
        logic [PRIO_W-1:0] level;
        logic [TIME_W-1:0] b;
        qi = (slice_quantum == 0) ? 1 : int'(slice_quantum);
        n_new = (loads_left == 0) ? 0 : $urandom_range(1, (loads_left < 4) ? loads_left : 4);
        level = PRIO_W'($urandom_range(0, 15));
        cost = $urandom_range(0, 3);
        for (int i = 0; i < n_new; i++)
        begin
            b = pick_burst(qi);
            ncost = (int'(b) + qi - 1) / qi;
            cost += (ncost > 40) ? 40 : ncost;
            if ($urandom_range(0, 3) == 0)
                push_load(PRIO_W'($urandom_range(0, 15)), b);
            else
                push_load(level, b);
            if ($urandom_range(0, 3) == 0)
                push_step();
        end
        loads_left -= n_new;
        if (n_new == 0)
            cost += $urandom_range(5, 25);
        // table full: the odd load is rejected
        if (loads_left == 0 && $urandom_range(0, 1) == 1)
            push_load(PRIO_W'($urandom), TIME_W'($urandom));
        for (int i = 0; i < cost; i++)
        begin
            push_step();
            if (loads_left > 0 && $urandom_range(0, 9) == 0)
            begin
                push_load(level, pick_burst(qi));   // joins the running group
                loads_left--;
            end
        end
    endtask

    // sender holds off until every expected result is back
    task automatic drain_results();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || start || due_results.size() != 0);
    endtask

    // only called with the block idle
    task automatic write_quantum(input logic [TIME_W-1:0] v);
        int n;
        n = cfg_writes;
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        while (cfg_writes == n)
            @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int rounds;
        int qsel;
        logic [TIME_W-1:0] qv;
        rounds = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed, default quantum of 10
        push_step();                      // empty table: all done
        push_load(4'd15, 16'hFFFF);       // lone top task runs its whole burst
        push_step();
        push_load(4'd0, 16'd0);           // zero burst: loaded, never runs
        push_step();
        push_load(4'd7, 16'd25);          // group of two at level 7
        push_load(4'd7, 16'd1);
        push_load(4'd3, 16'd12);
        push_step();
        push_step();
        push_load(4'd7, 16'd4);           // joins the running group
        push_load(4'd9, 16'd3);           // higher level waits for the group
        repeat (8) push_step();           // last one survives alone, then lone runs
        loads_left = MAX_TASKS - 7;
        drain_results();

        // random rounds; quantum rewritten between them while idle
        while (items_planned < ITEM_TARGET)
        begin
            if (rounds < 3 || $urandom_range(0, 1) == 1)
            begin
                qsel = $urandom_range(0, 9);
                case (rounds)
                    0: qv = 16'd1;
                    1: qv = 16'hFFFF;
                    2: qv = 16'd0;          // acts as 1
                    default:
                    begin
                        if (qsel < 4)
                            qv = TIME_W'($urandom_range(1, 4));
                        else if (qsel < 7)
                            qv = TIME_W'($urandom_range(5, 20));
                        else if (qsel == 7)
                            qv = 16'hFFFF;
                        else if (qsel == 8)
                            qv = 16'd0;
                        else
                            qv = TIME_W'($urandom_range(1, 65535));
                    end
                endcase
                write_quantum(qv);
            end
            // no idling toward the end of the run
            gaps_on = (items_planned < ITEM_TARGET - 80) && ($urandom_range(0, 2) != 0);
            @(posedge clk);
            plan_round();
            drain_results();
            rounds++;
        end

        repeat (SCAN_CYCLES) @(negedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never arrived", due_results.size(), 0);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/prrs_pkg.sv
hdl/prrs_ram.sv
hdl/priority_round_robin_scheduler.sv
hdl/prrs_checker.sv
sim/tb_priority_round_robin_scheduler.sv
